### hw/rtl/sgps_pkg.sv
// Shared constants, register codes and pipeline layout of the sky gradient shader.
package sgps_pkg;

	localparam int COORD_BITS = 12;
	localparam int DIM_W      = 13;
	localparam int HALF_W     = 16;
	localparam int ADDR_W     = 24;
	localparam int CH_W       = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 2'd0,
		CFG_FRAME_HEIGHT = 2'd1,
		CFG_HALF_VIEW_W  = 2'd2,
		CFG_HALF_VIEW_H  = 2'd3
	} cfg_idx_t;

	localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 13'd640;
	localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 13'd480;
	localparam logic [HALF_W-1:0] RST_HALF_VIEW_W  = 16'd3824;
	localparam logic [HALF_W-1:0] RST_HALF_VIEW_H  = 16'd2868;

	// Pipeline layout: stage numbers of each section.
	localparam int U_STEPS    = 17;  // quotient bits of c*2^16/(n-1)
	localparam int SQRT_STEPS = 17;  // root bits of a 34-bit sum
	localparam int NY_STEPS   = 16;  // quotient bits of |dy|*2^16/len
	localparam int S_UDIV     = 1;
	localparam int S_MAG      = S_UDIV + U_STEPS;
	localparam int S_PROD     = S_MAG + 1;
	localparam int S_SQR      = S_PROD + 1;
	localparam int S_SUM      = S_SQR + 1;
	localparam int S_SQRT     = S_SUM + 1;
	localparam int S_NDIV     = S_SQRT + SQRT_STEPS;
	localparam int S_LVL      = S_NDIV + NY_STEPS;
	localparam int S_GMUL     = S_LVL + 1;
	localparam int S_GLVL     = S_GMUL + 1;
	localparam int S_CMUL     = S_GLVL + 1;
	localparam int S_CDIV     = S_CMUL + 1;
	localparam int S_OUT      = S_CDIV + 1;

	// Reciprocals: ceil(2^24/10) and ceil(2^28/1000).
	localparam logic [20:0] RECIP_10   = 21'd1677722;
	localparam logic [18:0] RECIP_1000 = 19'd268436;
	localparam logic [17:0] CH_SCALE   = 18'd255999;

endpackage

### hw/rtl/sky_gradient_pixel_shader.sv
// Top level: pipelined sky gradient shader, one pixel per clock while the result is not stalled.
//
//  channel   | handshake                   | beat payload
//  ----------+-----------------------------+-----------------------------------------
//  pixel in  | pixel_valid / pixel_ready   | pixel_x, pixel_y
//  result    | result_valid / result_ready | pixel_address, red, green, blue, alpha
//  config    | cfg_we                      | cfg_index, cfg_data
//
// One beat per clock while the result is not stalled; the depth of the pipeline
// is set by the bit-per-stage dividers and square root.
// All stages advance together while the result register is empty or being taken.
// Pixels outside the frame are dropped at the entry stage.
// Reset clears the valid line and loads the default frame and viewport sizes.
module sky_gradient_pixel_shader (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pixel_valid,
	output logic                              pixel_ready,
	input  logic [sgps_pkg::COORD_BITS-1:0]   pixel_x,
	input  logic [sgps_pkg::COORD_BITS-1:0]   pixel_y,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic [sgps_pkg::ADDR_W-1:0]       pixel_address,
	output logic [sgps_pkg::CH_W-1:0]         red,
	output logic [sgps_pkg::CH_W-1:0]         green,
	output logic [sgps_pkg::CH_W-1:0]         blue,
	output logic [sgps_pkg::CH_W-1:0]         alpha,
	input  logic                              cfg_we,
	input  logic [sgps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sgps_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int LAST = sgps_pkg::S_OUT;
	localparam int UN   = sgps_pkg::U_STEPS;
	localparam int SN   = sgps_pkg::SQRT_STEPS;
	localparam int NN   = sgps_pkg::NY_STEPS;

	logic [12:0] frame_width_q, frame_height_q;
	logic [15:0] half_w_q, half_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= sgps_pkg::RST_FRAME_WIDTH;
			frame_height_q <= sgps_pkg::RST_FRAME_HEIGHT;
			half_w_q       <= sgps_pkg::RST_HALF_VIEW_W;
			half_h_q       <= sgps_pkg::RST_HALF_VIEW_H;
		end else if (cfg_we) begin
			case (sgps_pkg::cfg_idx_t'(cfg_index))
				sgps_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[12:0];
				sgps_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[12:0];
				sgps_pkg::CFG_HALF_VIEW_W:  half_w_q       <= cfg_data;
				sgps_pkg::CFG_HALF_VIEW_H:  half_h_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	logic        en;
	logic        in_frame;
	logic [12:0] div_x, div_y;
	logic        flat_x, flat_y;
	logic [24:0] addr_prod;

	logic                   vld_s  [0:LAST];
	logic [23:0]            addr_s [0:LAST];

	assign en          = !vld_s[LAST] || result_ready;
	assign pixel_ready = en;
	assign in_frame    = ({1'b0, pixel_x} < frame_width_q) && ({1'b0, pixel_y} < frame_height_q);
	assign addr_prod   = pixel_y * frame_width_q;
	assign div_x       = frame_width_q - 13'd1;
	assign div_y       = frame_height_q - 13'd1;
	assign flat_x      = frame_width_q <= 13'd1;
	assign flat_y      = frame_height_q <= 13'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= LAST; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= pixel_valid && in_frame;
			for (int i = 1; i <= LAST; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			addr_s[0] <= addr_prod[23:0] + {12'd0, pixel_x};
			for (int i = 1; i <= LAST; i++) addr_s[i] <= addr_s[i-1];
		end
	end

	// Entry stage
	logic [11:0] x_s1, y_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= pixel_x;
			y_s1 <= pixel_y;
		end
	end

	// Normalized coordinate u = c*2^16/(n-1), one quotient bit per stage.
	// c <= n-1 keeps the partial remainder below the divisor.
	logic [12:0] xrem_s [0:UN-1], yrem_s [0:UN-1];
	logic [16:0] xq_s   [0:UN-1], yq_s   [0:UN-1];
	logic [13:0] xpr    [0:UN-1], ypr    [0:UN-1];
	logic [13:0] xsub   [0:UN-1], ysub   [0:UN-1];
	logic [12:0] xrem_n [0:UN-1], yrem_n [0:UN-1];
	logic [16:0] xq_n   [0:UN-1], yq_n   [0:UN-1];

	always_comb begin
		for (int k = 0; k < UN; k++) begin
			if (k == 0) begin
				xpr[k]  = {2'b00, x_s1};
				ypr[k]  = {2'b00, y_s1};
				xq_n[k] = '0;
				yq_n[k] = '0;
			end else begin
				xpr[k]  = {xrem_s[k-1], 1'b0};
				ypr[k]  = {yrem_s[k-1], 1'b0};
				xq_n[k] = xq_s[k-1];
				yq_n[k] = yq_s[k-1];
			end
			xsub[k] = xpr[k] - {1'b0, div_x};
			ysub[k] = ypr[k] - {1'b0, div_y};
			if (xpr[k] >= {1'b0, div_x}) begin
				xrem_n[k] = xsub[k][12:0];
				xq_n[k][UN-1-k] = 1'b1;
			end else begin
				xrem_n[k] = xpr[k][12:0];
			end
			if (ypr[k] >= {1'b0, div_y}) begin
				yrem_n[k] = ysub[k][12:0];
				yq_n[k][UN-1-k] = 1'b1;
			end else begin
				yrem_n[k] = ypr[k][12:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < UN; k++) begin
				xrem_s[k] <= xrem_n[k];
				yrem_s[k] <= yrem_n[k];
				xq_s[k]   <= xq_n[k];
				yq_s[k]   <= yq_n[k];
			end
		end
	end

	// Distance from the center, then scale by the half viewport, square and sum.
	logic [16:0] ux, uy, mx_w, my_w;
	logic [15:0] mx_s18, my_s18;
	logic        negy_s18, negy_s19, negy_s20, negy_s21;
	logic [31:0] px_s19, py_s19;
	logic [15:0] ady_s20, ady_s21;
	logic [31:0] sqx_s20, sqy_s20;
	logic [33:0] sum_s21;

	assign ux   = xq_s[UN-1];
	assign uy   = yq_s[UN-1];
	assign mx_w = (ux[16] || ux[15]) ? ux - 17'd32768 : 17'd32768 - ux;
	assign my_w = (uy[16] || uy[15]) ? uy - 17'd32768 : 17'd32768 - uy;

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s18   <= flat_x ? 16'd0 : mx_w[15:0];
			my_s18   <= flat_y ? 16'd0 : my_w[15:0];
			negy_s18 <= uy[16] || uy[15];
			px_s19   <= mx_s18 * half_w_q;
			py_s19   <= my_s18 * half_h_q;
			negy_s19 <= negy_s18;
			sqx_s20  <= px_s19[30:15] * px_s19[30:15];
			sqy_s20  <= py_s19[30:15] * py_s19[30:15];
			ady_s20  <= py_s19[30:15];
			negy_s20 <= negy_s19;
			sum_s21  <= {2'b00, sqx_s20} + {2'b00, sqy_s20} + 34'd16777216;
			ady_s21  <= ady_s20;
			negy_s21 <= negy_s20;
		end
	end

	// Ray length: bit-pair square root, one root bit per stage.
	logic [33:0] sv_s   [0:SN-1];
	logic [34:0] sr_s   [0:SN-1];
	logic [15:0] sady_s [0:SN-1];
	logic        sneg_s [0:SN-1];
	logic [33:0] sv_p   [0:SN-1];
	logic [34:0] sr_p   [0:SN-1];
	logic [34:0] sbit   [0:SN-1];
	logic [34:0] strial [0:SN-1];
	logic [33:0] sv_n   [0:SN-1];
	logic [34:0] sr_n   [0:SN-1];

	always_comb begin
		for (int k = 0; k < SN; k++) begin
			if (k == 0) begin
				sv_p[k] = sum_s21;
				sr_p[k] = '0;
			end else begin
				sv_p[k] = sv_s[k-1];
				sr_p[k] = sr_s[k-1];
			end
			sbit[k]   = 35'd1 << (2 * (SN - 1 - k));
			strial[k] = sr_p[k] + sbit[k];
			if ({1'b0, sv_p[k]} >= strial[k]) begin
				sv_n[k] = sv_p[k] - strial[k][33:0];
				sr_n[k] = (sr_p[k] >> 1) + sbit[k];
			end else begin
				sv_n[k] = sv_p[k];
				sr_n[k] = sr_p[k] >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SN; k++) begin
				sv_s[k] <= sv_n[k];
				sr_s[k] <= sr_n[k];
			end
			sady_s[0] <= ady_s21;
			sneg_s[0] <= negy_s21;
			for (int k = 1; k < SN; k++) begin
				sady_s[k] <= sady_s[k-1];
				sneg_s[k] <= sneg_s[k-1];
			end
		end
	end

	// |ny| = |dy|*2^16/len; |dy| < len so the quotient fits 16 bits.
	logic [17:0] drem_s [0:NN-1];
	logic [15:0] dq_s   [0:NN-1];
	logic [17:0] dlen_s [0:NN-1];
	logic        dneg_s [0:NN-1];
	logic [18:0] dpr    [0:NN-1];
	logic [18:0] dsub   [0:NN-1];
	logic [17:0] dlen_p [0:NN-1];
	logic [17:0] drem_n [0:NN-1];
	logic [15:0] dq_n   [0:NN-1];

	always_comb begin
		for (int k = 0; k < NN; k++) begin
			if (k == 0) begin
				dpr[k]    = {2'b00, sady_s[SN-1], 1'b0};
				dlen_p[k] = sr_s[SN-1][17:0];
				dq_n[k]   = '0;
			end else begin
				dpr[k]    = {drem_s[k-1], 1'b0};
				dlen_p[k] = dlen_s[k-1];
				dq_n[k]   = dq_s[k-1];
			end
			dsub[k] = dpr[k] - {1'b0, dlen_p[k]};
			if (dpr[k] >= {1'b0, dlen_p[k]}) begin
				drem_n[k] = dsub[k][17:0];
				dq_n[k][NN-1-k] = 1'b1;
			end else begin
				drem_n[k] = dpr[k][17:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NN; k++) begin
				drem_s[k] <= drem_n[k];
				dq_s[k]   <= dq_n[k];
				dlen_s[k] <= dlen_p[k];
			end
			dneg_s[0] <= sneg_s[SN-1];
			for (int k = 1; k < NN; k++) dneg_s[k] <= dneg_s[k-1];
		end
	end

	// Blend levels and channel scaling.
	logic [17:0] t_sum;
	logic [16:0] t_w;
	logic [16:0] rlvl_s55, rlvl_s56, rlvl_s57;
	logic [17:0] g3_s55;
	logic [38:0] gq_s56;
	logic [16:0] glvl_s57;
	logic [34:0] pr_s58, pg_s58;
	logic [36:0] qr_s59, qg_s59;
	logic [7:0]  red_s60, green_s60;

	assign t_sum = dneg_s[NN-1] ? 18'd65536 - {2'b00, dq_s[NN-1]}
	                            : 18'd65536 + {2'b00, dq_s[NN-1]};
	assign t_w   = t_sum[17:1];

	always_ff @(posedge clk) begin
		if (en) begin
			rlvl_s55  <= 17'd65536 - {1'b0, t_w[16:1]};
			g3_s55    <= {1'b0, t_w} + {t_w, 1'b0};
			gq_s56    <= g3_s55 * sgps_pkg::RECIP_10;
			rlvl_s56  <= rlvl_s55;
			glvl_s57  <= 17'd65536 - {2'b00, gq_s56[38:24]};
			rlvl_s57  <= rlvl_s56;
			pr_s58    <= rlvl_s57 * sgps_pkg::CH_SCALE;
			pg_s58    <= glvl_s57 * sgps_pkg::CH_SCALE;
			qr_s59    <= pr_s58[33:16] * sgps_pkg::RECIP_1000;
			qg_s59    <= pg_s58[33:16] * sgps_pkg::RECIP_1000;
			red_s60   <= qr_s59[35:28];
			green_s60 <= qg_s59[35:28];
		end
	end

	assign result_valid  = vld_s[LAST];
	assign pixel_address = addr_s[LAST];
	assign red           = red_s60;
	assign green         = green_s60;
	assign blue          = 8'hFF;
	assign alpha         = 8'hFF;

endmodule

### hw/rtl/sgps_checker.sv
// Port-level checker for the sky gradient shader, bound to the top level.
module sgps_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pixel_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic [23:0] pixel_address,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic [7:0] alpha
);

	// An empty output stage never holds back the input.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> pixel_ready)
		else $error("input stalled with empty output");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(pixel_address)
			&& $stable(red) && $stable(green))
		else $error("stalled result changed");

	a_constant_channels: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> blue == 8'hFF && alpha == 8'hFF)
		else $error("blue or alpha not opaque white");

	// Blend toward (0.5,0.7,1.0) bounds the shaded channels from below.
	a_channel_floor: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> red >= 8'd127 && green >= 8'd179)
		else $error("shaded channel below gradient floor");

endmodule

bind sky_gradient_pixel_shader sgps_checker u_sgps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.pixel_ready   (pixel_ready),
	.result_valid  (result_valid),
	.result_ready  (result_ready),
	.pixel_address (pixel_address),
	.red           (red),
	.green         (green),
	.blue          (blue),
	.alpha         (alpha)
);
